// ===== sv/aipm_pkg.sv =====
// Package for the affine inverse point map unit.
// Holds the transaction payload types and fixed constants; no dependencies.
package aipm_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned DET_W   = 64;
   localparam int unsigned QUO_W   = 32;
   localparam logic [COORD_W-1:0] DET_EPS_RESET = 32'd43;
   localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic                        parent_present;
      logic signed [COORD_W-1:0]   lin_11;
      logic signed [COORD_W-1:0]   lin_12;
      logic signed [COORD_W-1:0]   lin_21;
      logic signed [COORD_W-1:0]   lin_22;
      logic signed [COORD_W-1:0]   trans_x;
      logic signed [COORD_W-1:0]   trans_y;
      logic signed [COORD_W-1:0]   world_x;
      logic signed [COORD_W-1:0]   world_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]   local_x;
      logic signed [COORD_W-1:0]   local_y;
      logic                        singular;
   } rsp_type;

   // Side information that rides alongside the divider.
   typedef struct packed {
      logic                        use_div;
      logic                        singular;
      logic signed [COORD_W-1:0]   world_x;
      logic signed [COORD_W-1:0]   world_y;
   } side_type;

endpackage

// ===== sv/affine_inverse_point_map_unit.sv =====
// Affine inverse point map unit: maps a world point through the inverse of a
// 2D affine matrix. One transaction is accepted per cycle while the pipeline
// advances; the front end and the 33-stage divider pipeline move together,
// advancing whenever the output register is empty or being drained.
// Synchronous active-high reset clears all valid bits and loads det_epsilon
// with 43; payload registers are not reset.
module affine_inverse_point_map_unit #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  aipm_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output aipm_pkg::rsp_type              rsp_data,
   input  logic                           csr_write_en,
   input  logic [aipm_pkg::COORD_W-1:0]   csr_write_data
);
   import aipm_pkg::*;

   localparam int unsigned NUM_W    = 2*COORD_W + 2 + FRAC_BITS;
   localparam int unsigned FRONT_LAT = 4;
   localparam int unsigned DIV_LAT  = QUO_W + 1;
   localparam int unsigned PIPE_LAT = FRONT_LAT + DIV_LAT;

   logic                  en;
   logic [COORD_W-1:0]    det_eps_ff;
   logic [PIPE_LAT-1:0]   vld_ff;
   side_type              front_side;
   logic [DET_W-1:0]      den;
   logic [NUM_W-1:0]      mag_x, mag_y;
   logic                  neg_x, neg_y;
   side_type              side_ff [0:DIV_LAT-1];
   logic [QUO_W-1:0]      quo_x, quo_y;
   logic                  ovf_x, ovf_y, nout_x, nout_y;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;

   // The whole pipeline moves together whenever the output slot frees up.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_eps_ff <= DET_EPS_RESET;
      end else if (csr_write_en) begin
         det_eps_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[PIPE_LAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   aipm_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
      .clock    (clock),
      .en       (en),
      .req_data (req_data),
      .det_eps  (det_eps_ff),
      .side     (front_side),
      .den      (den),
      .mag_x    (mag_x),
      .neg_x    (neg_x),
      .mag_y    (mag_y),
      .neg_y    (neg_y)
   );

   aipm_div #(.NUM_W(NUM_W)) u_div_x (
      .clock   (clock),
      .en      (en),
      .mag     (mag_x),
      .den     (den),
      .neg     (neg_x),
      .quo     (quo_x),
      .ovf     (ovf_x),
      .neg_out (nout_x)
   );

   aipm_div #(.NUM_W(NUM_W)) u_div_y (
      .clock   (clock),
      .en      (en),
      .mag     (mag_y),
      .den     (den),
      .neg     (neg_y),
      .quo     (quo_y),
      .ovf     (ovf_y),
      .neg_out (nout_y)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= front_side;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   function automatic logic signed [COORD_W-1:0] saturate(
      input logic [QUO_W-1:0] q, input logic ovf, input logic neg);
      logic signed [COORD_W-1:0] r;
      if (neg) begin
         r = (ovf || q[QUO_W-1]) ? SAT_MIN : COORD_W'(-$signed({1'b0, q}));
      end else begin
         r = (ovf || q[QUO_W-1]) ? SAT_MAX : $signed(q);
      end
      return r;
   endfunction

   always_comb begin
      rsp_data_in.singular = side_ff[DIV_LAT-1].singular;
      if (side_ff[DIV_LAT-1].use_div) begin
         rsp_data_in.local_x = saturate(quo_x, ovf_x, nout_x);
         rsp_data_in.local_y = saturate(quo_y, ovf_y, nout_y);
      end else begin
         rsp_data_in.local_x = side_ff[DIV_LAT-1].world_x;
         rsp_data_in.local_y = side_ff[DIV_LAT-1].world_y;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/aipm_front.sv =====
// Front end of the affine inverse point map: differences, products,
// determinant, magnitudes and the singular test in four register stages.
// Depends on aipm_pkg.
module aipm_front #(
   parameter int unsigned FRAC_BITS = 16,
   parameter int unsigned NUM_W     = 82
) (
   input  logic                              clock,
   input  logic                              en,
   input  aipm_pkg::req_type                 req_data,
   input  logic [aipm_pkg::COORD_W-1:0]      det_eps,
   output aipm_pkg::side_type                side,
   output logic [aipm_pkg::DET_W-1:0]        den,
   output logic [NUM_W-1:0]                  mag_x,
   output logic                              neg_x,
   output logic [NUM_W-1:0]                  mag_y,
   output logic                              neg_y
);
   import aipm_pkg::*;

   // Stage 1: input register and translation removal.
   logic                        s1_pass_ff;
   logic signed [COORD_W-1:0]   s1_l11_ff, s1_l12_ff, s1_l21_ff, s1_l22_ff;
   logic signed [COORD_W-1:0]   s1_wx_ff, s1_wy_ff;
   logic signed [COORD_W:0]     s1_dx_ff, s1_dy_ff;
   logic signed [COORD_W:0]     s1_dx_in, s1_dy_in;

   assign s1_dx_in = $signed({req_data.world_x[COORD_W-1], req_data.world_x})
                   - $signed({req_data.trans_x[COORD_W-1], req_data.trans_x});
   assign s1_dy_in = $signed({req_data.world_y[COORD_W-1], req_data.world_y})
                   - $signed({req_data.trans_y[COORD_W-1], req_data.trans_y});

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pass_ff <= req_data.parent_present;
         s1_l11_ff  <= req_data.lin_11;
         s1_l12_ff  <= req_data.lin_12;
         s1_l21_ff  <= req_data.lin_21;
         s1_l22_ff  <= req_data.lin_22;
         s1_wx_ff   <= req_data.world_x;
         s1_wy_ff   <= req_data.world_y;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
      end
   end

   // Stage 2: six products, each registered.
   logic                          s2_pass_ff;
   logic signed [COORD_W-1:0]     s2_wx_ff, s2_wy_ff;
   logic signed [2*COORD_W-1:0]   s2_da_ff, s2_db_ff;
   logic signed [2*COORD_W:0]     s2_xa_ff, s2_xb_ff, s2_ya_ff, s2_yb_ff;
   logic signed [2*COORD_W-1:0]   s2_da_in, s2_db_in;
   logic signed [2*COORD_W:0]     s2_xa_in, s2_xb_in, s2_ya_in, s2_yb_in;

   assign s2_da_in = s1_l11_ff * s1_l22_ff;
   assign s2_db_in = s1_l12_ff * s1_l21_ff;
   assign s2_xa_in = s1_dx_ff * s1_l22_ff;
   assign s2_xb_in = s1_dy_ff * s1_l21_ff;
   assign s2_ya_in = s1_dy_ff * s1_l11_ff;
   assign s2_yb_in = s1_dx_ff * s1_l12_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pass_ff <= s1_pass_ff;
         s2_wx_ff   <= s1_wx_ff;
         s2_wy_ff   <= s1_wy_ff;
         s2_da_ff   <= s2_da_in;
         s2_db_ff   <= s2_db_in;
         s2_xa_ff   <= s2_xa_in;
         s2_xb_ff   <= s2_xb_in;
         s2_ya_ff   <= s2_ya_in;
         s2_yb_ff   <= s2_yb_in;
      end
   end

   // Stage 3: determinant and numerators.
   logic                          s3_pass_ff;
   logic signed [COORD_W-1:0]     s3_wx_ff, s3_wy_ff;
   logic signed [2*COORD_W:0]     s3_det_ff, s3_det_in;
   logic signed [2*COORD_W+1:0]   s3_nx_ff, s3_ny_ff, s3_nx_in, s3_ny_in;

   assign s3_det_in = (2*COORD_W+1)'(s2_da_ff) - (2*COORD_W+1)'(s2_db_ff);
   assign s3_nx_in  = (2*COORD_W+2)'(s2_xa_ff) - (2*COORD_W+2)'(s2_xb_ff);
   assign s3_ny_in  = (2*COORD_W+2)'(s2_ya_ff) - (2*COORD_W+2)'(s2_yb_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_pass_ff <= s2_pass_ff;
         s3_wx_ff   <= s2_wx_ff;
         s3_wy_ff   <= s2_wy_ff;
         s3_det_ff  <= s3_det_in;
         s3_nx_ff   <= s3_nx_in;
         s3_ny_ff   <= s3_ny_in;
      end
   end

   // Stage 4: magnitudes, result signs and the singular test.
   logic                          s4_dneg;
   logic [2*COORD_W:0]            s4_det_abs;
   logic [DET_W-1:0]              s4_dmag;
   logic                          s4_small;
   logic [2*COORD_W+1:0]          s4_nx_abs, s4_ny_abs;
   side_type                      side_ff, side_in;
   logic [DET_W-1:0]              den_ff;
   logic [NUM_W-1:0]              mag_x_ff, mag_y_ff;
   logic                          neg_x_ff, neg_y_ff;

   assign s4_dneg    = s3_det_ff[2*COORD_W];
   assign s4_det_abs = s4_dneg ? (2*COORD_W+1)'(-s3_det_ff) : s3_det_ff;
   assign s4_dmag    = s4_det_abs[DET_W-1:0];
   assign s4_small   = (s4_dmag < {{(DET_W-COORD_W){1'b0}}, det_eps}) || (s4_dmag == '0);
   assign s4_nx_abs  = s3_nx_ff[2*COORD_W+1] ? (2*COORD_W+2)'(-s3_nx_ff) : s3_nx_ff;
   assign s4_ny_abs  = s3_ny_ff[2*COORD_W+1] ? (2*COORD_W+2)'(-s3_ny_ff) : s3_ny_ff;

   always_comb begin
      side_in.use_div  = s3_pass_ff && !s4_small;
      side_in.singular = s3_pass_ff && s4_small;
      side_in.world_x  = s3_wx_ff;
      side_in.world_y  = s3_wy_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff  <= side_in;
         den_ff   <= s4_dmag;
         mag_x_ff <= {s4_nx_abs, {FRAC_BITS{1'b0}}};
         mag_y_ff <= {s4_ny_abs, {FRAC_BITS{1'b0}}};
         neg_x_ff <= s3_nx_ff[2*COORD_W+1] ^ s4_dneg;
         neg_y_ff <= s3_ny_ff[2*COORD_W+1] ^ s4_dneg;
      end
   end

   assign side  = side_ff;
   assign den   = den_ff;
   assign mag_x = mag_x_ff;
   assign mag_y = mag_y_ff;
   assign neg_x = neg_x_ff;
   assign neg_y = neg_y_ff;

endmodule

// ===== sv/aipm_div.sv =====
// Pipelined restoring divider: one overflow-check stage, then one quotient
// bit per stage for a 32-bit quotient. Depends on aipm_pkg.
module aipm_div #(
   parameter int unsigned NUM_W = 82
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [NUM_W-1:0]                  mag,
   input  logic [aipm_pkg::DET_W-1:0]        den,
   input  logic                              neg,
   output logic [aipm_pkg::QUO_W-1:0]        quo,
   output logic                              ovf,
   output logic                              neg_out
);
   import aipm_pkg::*;

   localparam int unsigned HI_W = NUM_W - QUO_W;

   logic [DET_W-1:0]  rem_ff [0:QUO_W];
   logic [QUO_W-1:0]  lq_ff  [0:QUO_W];
   logic [DET_W-1:0]  den_ff [0:QUO_W];
   logic              ovf_ff [0:QUO_W];
   logic              neg_ff [0:QUO_W];
   logic [DET_W-1:0]  hi_in;

   // The quotient fits in 32 bits exactly when the upper numerator part is
   // below the divisor; that upper part then seeds the partial remainder.
   assign hi_in = {{(DET_W-HI_W){1'b0}}, mag[NUM_W-1:QUO_W]};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= hi_in;
         lq_ff[0]  <= mag[QUO_W-1:0];
         den_ff[0] <= den;
         ovf_ff[0] <= hi_in >= den;
         neg_ff[0] <= neg;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_bit
      logic [DET_W:0]   trial;
      logic             fits;
      logic [DET_W:0]   diff;

      assign trial = {rem_ff[k], lq_ff[k][QUO_W-1]};
      assign fits  = trial >= {1'b0, den_ff[k]};
      assign diff  = trial - {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= fits ? diff[DET_W-1:0] : trial[DET_W-1:0];
            lq_ff[k+1]  <= {lq_ff[k][QUO_W-2:0], fits};
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   assign quo     = lq_ff[QUO_W];
   assign ovf     = ovf_ff[QUO_W];
   assign neg_out = neg_ff[QUO_W];

endmodule

// ===== sv/aipm_checker.sv =====
// Port-level checker for the affine inverse point map unit, bound to the top.
// Depends on aipm_pkg.
module aipm_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  aipm_pkg::rsp_type    rsp_data
);
   import aipm_pkg::*;

   // Nothing comes out right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // The input side stalls only while a result is held back.
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output backpressure");

   // A held result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("held transaction changed");

   // A new result only appears when the output register was loaded by a pipeline advance.
   a_rise_on_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_ready))
      else $error("result appeared while the pipeline was stalled");

endmodule

bind affine_inverse_point_map_unit aipm_checker u_aipm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== bench/testbench.sv =====
// Testbench for affine_inverse_point_map_unit: random and directed affine inverse maps,
// checked against an in-bench exact fixed-point predictor. Depends on aipm_pkg and the RTL.
import aipm_pkg::*;

class point_map_scoreboard;
   rsp_type   pending[$];
   logic [31:0] epsilon = DET_EPS_RESET;
   int        errors = 0;

   // Signed 128-bit numerator shifted by F, divided by the determinant, saturated.
   function logic signed [31:0] quotient_sat(logic signed [127:0] num,
                                             logic signed [127:0] det);
      logic signed [127:0] q;
      begin
         q = num / det;
         if (q > 128'sd2147483647) return SAT_MAX;
         if (q < -128'sd2147483648) return SAT_MIN;
         return q[31:0];
      end
   endfunction

   function void note_request(req_type r);
      logic signed [127:0] det, mag, dx, dy, nx, ny;
      rsp_type e;
      begin
         e.local_x = r.world_x;
         e.local_y = r.world_y;
         e.singular = 1'b0;
         if (r.parent_present) begin
            det = 128'(r.lin_11) * 128'(r.lin_22) - 128'(r.lin_12) * 128'(r.lin_21);
            mag = det < 0 ? -det : det;
            if (mag < 128'(epsilon) || mag == 0) begin
               e.singular = 1'b1;
            end else begin
               dx = 128'(r.world_x) - 128'(r.trans_x);
               dy = 128'(r.world_y) - 128'(r.trans_y);
               nx = (dx * 128'(r.lin_22) - dy * 128'(r.lin_21)) <<< 16;
               ny = (dy * 128'(r.lin_11) - dx * 128'(r.lin_12)) <<< 16;
               e.local_x = quotient_sat(nx, det);
               e.local_y = quotient_sat(ny, det);
            end
         end
         pending = {pending, e};
      end
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_result(rsp_type got);
      rsp_type e;
      begin
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         e = pending.pop_front();
         if (got.local_x !== e.local_x)
            report($sformatf("local_x got %h exp %h", got.local_x, e.local_x));
         if (got.local_y !== e.local_y)
            report($sformatf("local_y got %h exp %h", got.local_y, e.local_y));
         if (got.singular !== e.singular)
            report($sformatf("singular got %b exp %b", got.singular, e.singular));
      end
   endtask
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;

   point_map_scoreboard board = new();
   int  cycles = 0;
   bit  calm = 1'b0;
   localparam int CYCLE_LIMIT = 200000;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   affine_inverse_point_map_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** affine_inverse_point_map_unit: FAILED **");
         $finish;
      end
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   // The receiver stalls at random about 7 percent of the time, except in the calm stretch.
   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= 7);

   function logic [31:0] rand_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(2, 0)) - 1) << 16;
         3: return $urandom_range(255);
         4: return 32'($signed($urandom_range(0, 6)) - 3) <<< 14;
         default: return $urandom;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with req_valid still high, so transactions can follow back to back.
   task send(req_type r);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task send_fields(logic p, logic [31:0] a, b, c, d, tx, ty, wx, wy);
      req_type r;
      begin
         r = '{p, a, b, c, d, tx, ty, wx, wy};
         send(r);
      end
   endtask

   task send_random();
      req_type r;
      begin
         r.parent_present = $urandom_range(9) != 0;
         r.lin_11 = rand_word(); r.lin_12 = rand_word();
         r.lin_21 = rand_word(); r.lin_22 = rand_word();
         r.trans_x = rand_word(); r.trans_y = rand_word();
         r.world_x = rand_word(); r.world_y = rand_word();
         // Sometimes make the matrix rank deficient or nearly so.
         if ($urandom_range(9) == 0) begin
            r.lin_21 = r.lin_11; r.lin_22 = r.lin_12 + $urandom_range(1);
         end
         send(r);
      end
   endtask

   // Stop sending, wait for every expected result, then keep idling so the pipeline empties.
   task drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task write_epsilon(logic [31:0] v);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_en <= 1'b0;
      board.epsilon = v;
   endtask

   localparam logic [31:0] ONE = 32'h0001_0000;
   logic [31:0] eps_list[5] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'd43};

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items.
      send_fields(0, 5, 6, 7, 8, 9, 10, 32'h8000_0000, 32'h7FFF_FFFF);
      send_fields(1, ONE, 0, 0, ONE, 0, 0, 32'h1234_5678, 32'hFEDC_BA98);
      send_fields(1, ONE, 0, 0, ONE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF);
      send_fields(1, 0, 0, 0, 0, 1, 2, 3, 4);
      send_fields(1, 1, 0, 0, 1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_fields(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  5, 6, 32'h8000_0000, 32'h8000_0000);
      send_fields(1, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1);
      send_fields(1, 7, 0, 0, 6, 0, 0, ONE, ONE);
      send_fields(1, 0, ONE, 32'hFFFF_0000, 0, ONE, 32'hFFFF_0000, 0, 0);
      send_fields(1, 32'h0002_0000, ONE, 32'h0004_0000, 32'h0002_0000, 1, 1, 9, 9);
      send_fields(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();

      // The sender pauses until the pipeline is empty before each new setting.
      foreach (eps_list[i]) begin
         write_epsilon(eps_list[i]);
         if (i == 1) send_fields(1, 0, 0, 0, 0, 1, 2, 3, 4);
         if (i == 2) send_fields(1, ONE, 0, 0, ONE, 0, 0, 77, 88);
         calm = (i == 3);
         repeat (290) send_random();
         drain();
      end
      calm = 1'b0;

      if (board.errors == 0 && board.pending.size() == 0)
         $display("** affine_inverse_point_map_unit: PASSED **");
      else
         $display("** affine_inverse_point_map_unit: FAILED **");
      $finish;
   end
endmodule
